// File: sv/ts_pkg.sv
package ts_pkg;

   // Number of odd Taylor terms that are summed (1 to 8).
   localparam int TERMS = 6;

   // Restoring reduction cells: the quotient of the reduction is below 32.
   localparam int MOD_CELLS = 5;

   localparam logic [63:0] PI_Q60      = 64'h3243_F6A8_885A_308D;
   localparam logic [63:0] HALF_PI_Q60 = PI_Q60 >> 1;
   localparam logic [63:0] TWO_PI_Q56  = PI_Q60 >> 3;
   localparam logic [63:0] ROUND_Q30   = 64'd536870912;

   // Largest folded angle after rounding to Q.30.
   localparam logic [30:0] X_MAX = 31'((HALF_PI_Q60 + ROUND_Q30) >> 30);

   localparam int DIV_W   = 9;
   localparam int RECIP_W = 30;
   localparam longint TWO_32 = 64'h1_0000_0000;

   // Term k of the series is divided by (2k+2)(2k+3).
   localparam logic [DIV_W-1:0] DIVS [8] = '{
      9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272
   };

   // Reciprocals floor(2^32 / divisor), one short at most after truncation.
   localparam logic [RECIP_W-1:0] RECIPS [8] = '{
      30'(TWO_32 / 6),   30'(TWO_32 / 20),  30'(TWO_32 / 42),  30'(TWO_32 / 72),
      30'(TWO_32 / 110), 30'(TWO_32 / 156), 30'(TWO_32 / 210), 30'(TWO_32 / 272)
   };

   typedef struct packed {
      logic [63:0] n;
      logic        neg;
   } mod_beat_type;

   typedef struct packed {
      logic [30:0] term;
      logic [31:0] x2;
      logic [31:0] sum;
      logic        flip;
   } ser_beat_type;

endpackage

// File: sv/ts_mod_cell.sv
module ts_mod_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [63:0]          dvs,
   input  logic                 in_valid,
   input  ts_pkg::mod_beat_type in_beat,
   output logic                 in_ready,
   output logic                 out_valid,
   output ts_pkg::mod_beat_type out_beat,
   input  logic                 out_ready
);

   logic                 v_ff, v_in, en;
   ts_pkg::mod_beat_type beat_ff, beat_in;

   // One restoring step: take the shifted modulus off when it fits.
   always_comb begin
      en       = !v_ff || out_ready;
      v_in     = en ? in_valid : v_ff;
      beat_in  = beat_ff;
      if (en) begin
         beat_in.neg = in_beat.neg;
         beat_in.n   = (in_beat.n >= dvs) ? in_beat.n - dvs : in_beat.n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
      beat_ff <= beat_in;
   end

   assign in_ready  = en;
   assign out_valid = v_ff;
   assign out_beat  = beat_ff;

   a_rem_below_dvs: assert property (@(posedge clock) disable iff (reset)
      v_ff |-> beat_ff.n < dvs)
      else $error("reduction cell left a remainder not below its modulus");

endmodule

// File: sv/ts_fold.sv
module ts_fold (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  ts_pkg::mod_beat_type in_beat,
   output logic                 in_ready,
   output logic                 out_valid,
   output ts_pkg::ser_beat_type out_beat,
   input  logic                 out_ready
);

   logic [4:0]  v_ff, v_in, en;
   logic [63:0] s1_r_ff, s1_r_in;
   logic [63:0] s2_r_ff, s2_r_in;
   logic        s2_flip_ff, s2_flip_in;
   logic [63:0] s3_r_ff, s3_r_in;
   logic        s3_flip_ff, s3_flip_in;
   logic [30:0] s4_x_ff, s4_x_in;
   logic        s4_flip_ff, s4_flip_in;
   ts_pkg::ser_beat_type s5_beat_ff, s5_beat_in;
   logic [63:0] r_up, rnd;
   logic [61:0] sq;

   always_comb begin
      en[4] = !v_ff[4] || out_ready;
      for (int i = 3; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
      v_in[0] = en[0] ? in_valid : v_ff[0];
      for (int i = 1; i < 5; i++) begin
         v_in[i] = en[i] ? v_ff[i-1] : v_ff[i];
      end
   end

   // A negative angle with a nonzero remainder wraps up to 2pi minus it.
   assign r_up    = (in_beat.neg && (in_beat.n != 64'd0)) ?
                    ts_pkg::TWO_PI_Q56 - in_beat.n : in_beat.n;
   assign s1_r_in = en[0] ? {r_up[59:0], 4'b0000} : s1_r_ff;

   always_comb begin
      s2_r_in    = s2_r_ff;
      s2_flip_in = s2_flip_ff;
      if (en[1]) begin
         s2_flip_in = s1_r_ff > ts_pkg::PI_Q60;
         s2_r_in    = s2_flip_in ? s1_r_ff - ts_pkg::PI_Q60 : s1_r_ff;
      end
   end

   always_comb begin
      s3_r_in    = s3_r_ff;
      s3_flip_in = s3_flip_ff;
      if (en[2]) begin
         s3_flip_in = s2_flip_ff;
         s3_r_in    = (s2_r_ff > ts_pkg::HALF_PI_Q60) ? ts_pkg::PI_Q60 - s2_r_ff : s2_r_ff;
      end
   end

   assign rnd        = s3_r_ff + ts_pkg::ROUND_Q30;
   assign s4_x_in    = en[3] ? rnd[60:30] : s4_x_ff;
   assign s4_flip_in = en[3] ? s3_flip_ff : s4_flip_ff;

   assign sq = 62'(s4_x_ff) * 62'(s4_x_ff);

   always_comb begin
      s5_beat_in = s5_beat_ff;
      if (en[4]) begin
         s5_beat_in.term = s4_x_ff;
         s5_beat_in.x2   = sq[61:30];
         s5_beat_in.sum  = 32'd0;
         s5_beat_in.flip = s4_flip_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 5'b00000;
      end else begin
         v_ff <= v_in;
      end
      s1_r_ff    <= s1_r_in;
      s2_r_ff    <= s2_r_in;
      s2_flip_ff <= s2_flip_in;
      s3_r_ff    <= s3_r_in;
      s3_flip_ff <= s3_flip_in;
      s4_x_ff    <= s4_x_in;
      s4_flip_ff <= s4_flip_in;
      s5_beat_ff <= s5_beat_in;
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[4];
   assign out_beat  = s5_beat_ff;

   a_x_in_quadrant: assert property (@(posedge clock) disable iff (reset)
      v_ff[3] |-> s4_x_ff <= ts_pkg::X_MAX)
      else $error("folded angle lies beyond pi/2");

endmodule

// File: sv/ts_term_cell.sv
module ts_term_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [ts_pkg::DIV_W-1:0]     div,
   input  logic [ts_pkg::RECIP_W-1:0]   recip,
   input  logic                         subtract,
   input  logic                         in_valid,
   input  ts_pkg::ser_beat_type         in_beat,
   output logic                         in_ready,
   output logic                         out_valid,
   output ts_pkg::ser_beat_type         out_beat,
   input  logic                         out_ready
);

   logic [2:0]                 v_ff, v_in, en;
   ts_pkg::ser_beat_type       a_beat_ff, a_beat_in;
   logic [31:0]                a_p_ff, a_p_in;
   ts_pkg::ser_beat_type       b_beat_ff, b_beat_in;
   logic [31:0]                b_p_ff, b_p_in;
   logic [ts_pkg::RECIP_W-1:0] b_q0_ff, b_q0_in;
   ts_pkg::ser_beat_type       c_beat_ff, c_beat_in;
   logic [62:0]                prod_a;
   logic [61:0]                prod_b;
   logic [38:0]                qd;
   logic [31:0]                rem;
   logic                       bump;

   always_comb begin
      en[2] = !v_ff[2] || out_ready;
      en[1] = !v_ff[1] || en[2];
      en[0] = !v_ff[0] || en[1];
      v_in[0] = en[0] ? in_valid : v_ff[0];
      v_in[1] = en[1] ? v_ff[0]  : v_ff[1];
      v_in[2] = en[2] ? v_ff[1]  : v_ff[2];
   end

   // Add this term into the sum and raise the term by x^2.
   assign prod_a = 63'(in_beat.term) * 63'(in_beat.x2);

   always_comb begin
      a_beat_in = a_beat_ff;
      a_p_in    = a_p_ff;
      if (en[0]) begin
         a_beat_in     = in_beat;
         a_beat_in.sum = subtract ? in_beat.sum - 32'(in_beat.term)
                                  : in_beat.sum + 32'(in_beat.term);
         a_p_in        = prod_a[61:30];
      end
   end

   // Divide by the factorial step through its reciprocal; the estimate is
   // at most one short of the true quotient.
   assign prod_b  = 62'(a_p_ff) * 62'(recip);
   assign b_beat_in = en[1] ? a_beat_ff    : b_beat_ff;
   assign b_p_in    = en[1] ? a_p_ff       : b_p_ff;
   assign b_q0_in   = en[1] ? prod_b[61:32] : b_q0_ff;

   assign qd   = 39'(b_q0_ff) * 39'(div);
   assign rem  = b_p_ff - qd[31:0];
   assign bump = rem >= 32'(div);

   always_comb begin
      c_beat_in = c_beat_ff;
      if (en[2]) begin
         c_beat_in      = b_beat_ff;
         c_beat_in.term = 31'(b_q0_ff) + 31'(bump);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 3'b000;
      end else begin
         v_ff <= v_in;
      end
      a_beat_ff <= a_beat_in;
      a_p_ff    <= a_p_in;
      b_beat_ff <= b_beat_in;
      b_p_ff    <= b_p_in;
      b_q0_ff   <= b_q0_in;
      c_beat_ff <= c_beat_in;
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[2];
   assign out_beat  = c_beat_ff;

   a_recip_error: assert property (@(posedge clock) disable iff (reset)
      v_ff[1] |-> rem < 32'({div, 1'b0}))
      else $error("reciprocal quotient estimate is off by more than one");

   a_sum_nonneg: assert property (@(posedge clock) disable iff (reset)
      v_ff[2] |-> !c_beat_ff.sum[31])
      else $error("partial Taylor sum went negative");

endmodule

// File: sv/taylor_sine.sv
// taylor_sine: fixed-point sine by a truncated odd Taylor series.
//
// The request channel takes one signed Q8.24 angle in radians per beat
// (req_valid, req_angle, req_stall). The response channel gives its sine as
// a signed Q2.30 value per beat (rsp_valid, rsp_sine, rsp_stall). Results
// leave in the order the angles came in, one result for every angle.
//
// A new angle is taken every cycle unless the pipe is full behind rsp_stall.
// The pipe holds one entry stage, five reduction cells, five fold and squaring
// stages, three stages in each series cell (multiply, reciprocal multiply,
// quotient correction) and the output register.
//
// Every stage holds its own valid bit and moves forward whenever the stage
// after it is empty or moving, so empty slots close up. While rsp_stall is
// high the response beat holds and the pipe keeps taking angles until it is
// full; with rsp_stall low, req_stall is low.
//
// Reset is synchronous and clears only the valid bits; the pipe is empty and
// ready in the first cycle after reset is released.
module taylor_sine (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic signed [31:0] req_angle,
   output logic               req_stall,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_sine,
   input  logic               rsp_stall
);

   localparam int NM = ts_pkg::MOD_CELLS;
   localparam int NT = ts_pkg::TERMS;

   // Entry stage: the magnitude of the angle moved to Q.56. The most
   // negative angle negates to 2^31, which the 32 unsigned bits still hold.
   logic                 e_v_ff, e_v_in, e_en;
   ts_pkg::mod_beat_type e_beat_ff, e_beat_in;
   logic [31:0]          ang_bits, mag;

   assign ang_bits = req_angle;
   assign mag      = ang_bits[31] ? (~ang_bits + 32'd1) : ang_bits;

   always_comb begin
      e_v_in    = e_en ? req_valid : e_v_ff;
      e_beat_in = e_beat_ff;
      if (e_en) begin
         e_beat_in.n   = {mag, 32'd0};
         e_beat_in.neg = ang_bits[31];
      end
   end

   // Reduction modulo 2pi: a chain of restoring cells, each taking off
   // 2pi shifted left by one bit less than the cell before it.
   logic                 mv [NM+1];
   ts_pkg::mod_beat_type mb [NM+1];
   logic                 mr [NM+1];

   assign mv[0] = e_v_ff;
   assign mb[0] = e_beat_ff;
   assign e_en  = !e_v_ff || mr[0];

   for (genvar i = 0; i < NM; i++) begin : g_mod
      ts_mod_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .dvs       (ts_pkg::TWO_PI_Q56 << (NM - 1 - i)),
         .in_valid  (mv[i]),
         .in_beat   (mb[i]),
         .in_ready  (mr[i]),
         .out_valid (mv[i+1]),
         .out_beat  (mb[i+1]),
         .out_ready (mr[i+1])
      );
   end

   // Fold into the first quadrant, round to Q.30 and square.
   logic                 tv [NT+1];
   ts_pkg::ser_beat_type tb [NT+1];
   logic                 tr [NT+1];

   ts_fold u_fold (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mv[NM]),
      .in_beat   (mb[NM]),
      .in_ready  (mr[NM]),
      .out_valid (tv[0]),
      .out_beat  (tb[0]),
      .out_ready (tr[0])
   );

   // Series cells: cell k adds term k with its alternating sign and hands
   // the next term, term * x^2 / ((2k+2)(2k+3)), to its neighbor.
   for (genvar k = 0; k < NT; k++) begin : g_term
      ts_term_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .div       (ts_pkg::DIVS[k]),
         .recip     (ts_pkg::RECIPS[k]),
         .subtract  ((k % 2) == 1),
         .in_valid  (tv[k]),
         .in_beat   (tb[k]),
         .in_ready  (tr[k]),
         .out_valid (tv[k+1]),
         .out_beat  (tb[k+1]),
         .out_ready (tr[k+1])
      );
   end

   // Output register. The sum of a decreasing alternating series lies
   // between zero and the folded angle, below pi/2 in Q.30, so it never
   // reaches the 32-bit limits and the negation cannot overflow.
   logic        rsp_valid_ff, rsp_valid_in, o_en;
   logic [31:0] rsp_sine_ff, rsp_sine_in;

   assign o_en         = !rsp_valid_ff || !rsp_stall;
   assign tr[NT]       = o_en;
   assign rsp_valid_in = o_en ? tv[NT] : rsp_valid_ff;
   assign rsp_sine_in  = o_en ? (tb[NT].flip ? (~tb[NT].sum + 32'd1) : tb[NT].sum)
                              : rsp_sine_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         e_v_ff       <= e_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      e_beat_ff   <= e_beat_in;
      rsp_sine_ff <= rsp_sine_in;
   end

   assign req_stall = !e_en;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_sine  = rsp_sine_ff;

   a_ready_through: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request side stalled while the response side is free");

endmodule

// File: bench/tb.sv
// Self-checking bench for taylor_sine.
//
// An initial block fills a backlog of angles: a short directed list first
// (zero, the extremes of the field, and points just around the pi/2, pi, 3pi/2
// and 2pi fold boundaries on both sides of zero), then random angles drawn
// from a mix of full-range words, moderate angles, angles near multiples of
// pi/2 and tiny angles. A clocked driver offers the backlog on the request
// channel with random gaps. Every request beat that is taken is run through
// a bit-exact model of the series datapath, and the expected sine is queued.
// A clocked monitor stalls the response channel at random and compares each
// response beat with the oldest queued sine.
module tb;

   timeunit 1ns;
   timeprecision 1ps;

   // Fold points of the angle, in the Q8.24 format of the request field.
   localparam logic signed [31:0] PI_Q24      = 32'(ts_pkg::PI_Q60 >> 36);
   localparam logic signed [31:0] HALF_PI_Q24 = 32'(ts_pkg::HALF_PI_Q60 >> 36);
   localparam logic signed [31:0] TWO_PI_Q24  = 32'(ts_pkg::TWO_PI_Q56 >> 32);

   localparam int ANGLE_COUNT  = 1350;
   localparam int GAP_PERCENT  = 32;
   localparam int REPORT_LIMIT = 10;
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 60;
   localparam int STUCK_LIMIT  = 2000;

   typedef struct {
      logic signed [31:0] angle;
      logic signed [31:0] sine;
   } sine_entry_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic signed [31:0] req_angle = '0;
   logic               req_stall;
   logic               rsp_valid;
   logic signed [31:0] rsp_sine;
   logic               rsp_stall = 1'b0;

   logic signed [31:0] angle_backlog [$];
   sine_entry_type     sine_expected [$];

   int angles_taken = 0;
   int sines_seen = 0;
   int fail_count = 0;
   int stuck_cycles = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   taylor_sine uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_angle (req_angle),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_sine  (rsp_sine),
      .rsp_stall (rsp_stall)
   );

   always #5 clock = ~clock;

   // Clamp a 64-bit sum into the signed 32-bit range of the result.
   function automatic longint clamp_q230(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Bit-exact sine of a Q8.24 angle as a Q2.30 word. The angle magnitude is
   // reduced modulo 2pi in Q.56, a negative angle is wrapped up to 2pi minus
   // its remainder, the pi and pi/2 folds are done in Q.60, and the series
   // runs in Q.30 with truncating multiplies and divisions.
   function automatic logic signed [31:0] sine_of(input logic signed [31:0] angle);
      logic [63:0] mag;
      logic [63:0] rem;
      logic [63:0] r60;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] divisor;
      bit          flip;
      longint      acc;
      mag = angle[31] ? (64'h1_0000_0000 - {32'b0, angle}) : {32'b0, angle};
      rem = (mag << 32) % ts_pkg::TWO_PI_Q56;
      if (angle[31] && rem != 64'd0)
         rem = ts_pkg::TWO_PI_Q56 - rem;
      r60 = rem << 4;
      flip = 1'b0;
      if (r60 > ts_pkg::PI_Q60) begin
         flip = 1'b1;
         r60 = r60 - ts_pkg::PI_Q60;
      end
      if (r60 > ts_pkg::HALF_PI_Q60)
         r60 = ts_pkg::PI_Q60 - r60;
      x = (r60 + ts_pkg::ROUND_Q30) >> 30;
      x2 = (x * x) >> 30;
      term = x;
      acc = 0;
      for (int k = 0; k < ts_pkg::TERMS; k++) begin
         if (k % 2 == 1)
            acc = acc - longint'(term);
         else
            acc = acc + longint'(term);
         divisor = 64'(2 * k + 2) * 64'(2 * k + 3);
         term = ((term * x2) >> 30) / divisor;
      end
      acc = clamp_q230(acc);
      if (flip)
         acc = clamp_q230(-acc);
      return 32'(acc);
   endfunction

   // Request driver. When the current beat is taken, its expected sine is
   // queued. A new beat, or a gap, is chosen only when the channel is free,
   // so a stalled beat keeps its angle and the valid never drops under stall.
   always @(posedge clock) begin : drive_angles
      bit gap;
      if (reset) begin
         req_valid <= 1'b0;
         req_angle <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            sine_expected.push_back('{angle: req_angle, sine: sine_of(req_angle)});
            angles_taken++;
         end
         if (!req_valid || !req_stall) begin
            // Gaps are skipped over a long middle stretch of the run.
            gap = ($urandom_range(99) < GAP_PERCENT) &&
                  !(angles_taken >= 600 && angles_taken < 900);
            if (angle_backlog.size() != 0 && !gap) begin
               req_valid <= 1'b1;
               req_angle <= angle_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor. Each beat that is taken is checked against the oldest
   // expected sine. The stall is random, except for one long hold-off that
   // lets the pipe fill and push back on the request side, and a middle
   // stretch with no stall at all.
   always @(posedge clock) begin : check_sines
      sine_entry_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            sines_seen++;
            if (sine_expected.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("unexpected sine beat: got %h", rsp_sine);
            end else begin
               want = sine_expected.pop_front();
               if (rsp_sine !== want.sine) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT)
                     $display("sine mismatch for angle %h: expected %h, got %h",
                              want.angle, want.sine, rsp_sine);
               end
            end
         end
         if (!hold_done && sines_seen >= 300) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= (hold_left > 1);
         end else begin
            rsp_stall <= ($urandom_range(99) < GAP_PERCENT) &&
                         !(sines_seen >= 600 && sines_seen < 900);
         end
      end
   end

   // Watchdog: the run is stuck once no beat has moved on either channel for
   // far longer than the hold-off, the pipe depth and any random gap.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("taylor_sine verification failed");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin : run_test
      logic signed [31:0] directed [$];
      int k;
      // Directed angles: zero, unit steps, both field extremes, and the fold
      // boundaries on both sides of zero, several with their neighbors.
      directed = '{
         32'sd0, 32'sd1, -32'sd1,
         32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0001,
         HALF_PI_Q24, HALF_PI_Q24 + 1, HALF_PI_Q24 - 1,
         PI_Q24, PI_Q24 + 1, PI_Q24 - 1,
         PI_Q24 + HALF_PI_Q24, TWO_PI_Q24, TWO_PI_Q24 + 1, TWO_PI_Q24 - 1,
         -HALF_PI_Q24, -PI_Q24, -PI_Q24 - 1, -(PI_Q24 + HALF_PI_Q24),
         -TWO_PI_Q24, -TWO_PI_Q24 + 1, 32'sh0100_0000, -32'sh0100_0000
      };
      foreach (directed[i])
         angle_backlog.push_back(directed[i]);

      // Random angles. Full-range words exercise every bit of the field and
      // the deep reduction; the others stay where the series does its work.
      while (angle_backlog.size() < ANGLE_COUNT) begin
         case ($urandom_range(3))
            0: angle_backlog.push_back($urandom);
            1: angle_backlog.push_back(
                  int'($urandom_range(32'h1000_0000)) - 32'sh0800_0000);
            2: begin
               k = int'($urandom_range(160)) - 80;
               angle_backlog.push_back(k * HALF_PI_Q24 +
                                       int'($urandom_range(128)) - 64);
            end
            default: angle_backlog.push_back(int'($urandom_range(8192)) - 4096);
         endcase
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Wait for every angle to go in and every sine to come out, then let
      // the pipe run on long enough to expose any stray response beat.
      while (angles_taken < ANGLE_COUNT || sine_expected.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && sine_expected.size() == 0) begin
         $display("taylor_sine verification clean");
      end else begin
         $display("taylor_sine verification failed");
      end
      $finish;
   end

endmodule
